// ----- rtl/core/tptq_pkg.sv -----
// ----------------------------------------------------------------------------
// tptq_pkg
// Shared types and constants for the timed priority transmit queue.
// ----------------------------------------------------------------------------
package tptq_pkg;

    localparam int OP_W     = 3;
    localparam int HANDLE_W = 5;
    localparam int PRIO_W   = 8;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
    localparam logic [OP_W-1:0] OP_TAKE    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT   = 3'd4;

    // Entries at this priority are never picked by a take.
    localparam logic [PRIO_W-1:0] PRIO_NEVER = 8'd255;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   priority_req;
        logic [TIME_W-1:0]   release_time;
        logic [TIME_W-1:0]   now;
        logic [SLOT_W-1:0]   slot;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] out_handle;
        logic [SLOT_W-1:0]   out_slot;
        logic                dropped;
        logic [HANDLE_W-1:0] dropped_handle;
        logic [COUNT_W-1:0]  ready_count;
    } t_out_item;

    // One stored slot, 45 bits.
    typedef struct packed {
        logic [TIME_W-1:0]   rel_time;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic start;   // capture the request and clear the scan results
        logic scan;    // issue the read of the next slot
        logic commit;  // apply the table update and load the result
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;  // the read being issued is the last slot
        logic out_free;   // the result register can take a new value
    } t_dp_sts;

endpackage

// ----- rtl/core/tptq_ram.sv -----
// ----------------------------------------------------------------------------
// tptq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tptq_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/tptq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tptq_ctrl
// Sequencer for one operation: accept, scan all slots, drain, commit.
// ----------------------------------------------------------------------------
module tptq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tptq_pkg::t_dp_sts i_sts,
    output tptq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The data of the last slot is checked in this cycle.
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit issued while the result register is still occupied");

    a_scan_leads_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan && i_sts.scan_last) |=> (r_state == ST_DRAIN))
        else $error("last slot read not followed by the drain cycle");

    a_start_only_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> (o_in_ready && i_in_valid))
        else $error("operation started without an accepted transaction");

endmodule

// ----- rtl/core/tptq_dp.sv -----
// ----------------------------------------------------------------------------
// tptq_dp
// Datapath: slot RAM, valid bits, per-slot scan accumulators, result register.
// ----------------------------------------------------------------------------
module tptq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tptq_pkg::t_dp_cmd   i_cmd,
    output tptq_pkg::t_dp_sts   o_sts,
    input  tptq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tptq_pkg::t_out_item o_out_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int SLOT_W = tptq_pkg::SLOT_W;
    localparam int COUNT_W = tptq_pkg::COUNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    tptq_pkg::t_in_item  r_req;
    tptq_pkg::t_out_item r_out;
    tptq_pkg::t_out_item n_out;
    logic                r_out_valid;

    logic [QUEUE_DEPTH-1:0] r_slot_valid;

    logic [IDX_W-1:0] r_scan_idx;
    logic             r_chk_vld;
    logic [IDX_W-1:0] r_chk_idx;

    logic [COUNT_W-1:0]            r_ready_cnt;
    logic                          r_have_free;
    logic [IDX_W-1:0]              r_free_idx;
    logic                          r_have_best;
    logic [tptq_pkg::PRIO_W-1:0]   r_best_prio;
    logic [IDX_W-1:0]              r_best_idx;
    logic [tptq_pkg::HANDLE_W-1:0] r_best_handle;
    logic                          r_sel_found;
    logic [tptq_pkg::HANDLE_W-1:0] r_sel_handle;
    logic [tptq_pkg::HANDLE_W-1:0] r_drop_handle;

    logic [tptq_pkg::ENTRY_W-1:0] ram_rdata;
    logic [tptq_pkg::ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]             ram_waddr;
    logic                         ram_we;

    tptq_pkg::t_entry rd_entry;
    tptq_pkg::t_entry new_entry;
    logic             table_full;
    logic             shift_down;
    logic             chk_slot_valid;
    logic             chk_ready;
    logic             chk_better;
    logic             chk_selected;
    logic [IDX_W-1:0] enq_idx;
    logic             is_enqueue;

    tptq_ram #(
        .WIDTH (tptq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry   = tptq_pkg::t_entry'(ram_rdata);
    assign new_entry  = '{rel_time: r_req.release_time,
                          prio:     r_req.priority_req,
                          handle:   r_req.handle};
    assign table_full = &r_slot_valid;
    assign is_enqueue = (r_req.operation == tptq_pkg::OP_ENQUEUE);
    // A full table moves every slot down by one while it is scanned.
    assign shift_down = is_enqueue && table_full;
    assign enq_idx    = table_full ? LAST_IDX : r_free_idx;

    assign chk_slot_valid = r_slot_valid[r_chk_idx];
    assign chk_ready      = chk_slot_valid && (rd_entry.rel_time <= r_req.now);
    assign chk_better     = chk_ready && (rd_entry.prio < r_best_prio);
    assign chk_selected   = chk_slot_valid && (SLOT_W'(r_chk_idx) == r_req.slot);

    // The scan write and the commit write fall in different cycles.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_chk_idx - IDX_W'(1);
        ram_wdata = ram_rdata;
        if (i_cmd.commit && is_enqueue) begin
            ram_we    = 1'b1;
            ram_waddr = enq_idx;
            ram_wdata = new_entry;
        end else if (r_chk_vld && shift_down && (r_chk_idx != '0)) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_out             = '0;
        n_out.ready_count = r_ready_cnt;
        unique case (r_req.operation) inside
            tptq_pkg::OP_ENQUEUE: begin
                n_out.out_slot = SLOT_W'(enq_idx);
                n_out.dropped  = table_full;
                if (table_full) begin
                    n_out.dropped_handle = r_drop_handle;
                end
            end
            tptq_pkg::OP_TAKE: begin
                if (r_have_best) begin
                    n_out.found      = 1'b1;
                    n_out.out_handle = r_best_handle;
                    n_out.out_slot   = SLOT_W'(r_best_idx);
                end
            end
            tptq_pkg::OP_PEEK, tptq_pkg::OP_REMOVE: begin
                if (r_sel_found) begin
                    n_out.found      = 1'b1;
                    n_out.out_handle = r_sel_handle;
                    n_out.out_slot   = r_req.slot;
                end
            end
            default: begin
                n_out.found = 1'b0;
            end
        endcase
    end

    // Scan control and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld  <= 1'b0;
            r_scan_idx <= '0;
        end else begin
            r_chk_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req         <= i_in_data;
            r_ready_cnt   <= '0;
            r_have_free   <= 1'b0;
            r_free_idx    <= '0;
            r_have_best   <= 1'b0;
            r_best_prio   <= tptq_pkg::PRIO_NEVER;
            r_best_idx    <= '0;
            r_best_handle <= '0;
            r_sel_found   <= 1'b0;
            r_sel_handle  <= '0;
            r_drop_handle <= '0;
        end else if (r_chk_vld) begin
            r_ready_cnt <= r_ready_cnt + COUNT_W'(chk_ready);
            if (!chk_slot_valid && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_chk_idx;
            end
            // Strict compare keeps the lowest slot on equal priority.
            if (chk_better) begin
                r_have_best   <= 1'b1;
                r_best_prio   <= rd_entry.prio;
                r_best_idx    <= r_chk_idx;
                r_best_handle <= rd_entry.handle;
            end
            if (chk_selected) begin
                r_sel_found  <= 1'b1;
                r_sel_handle <= rd_entry.handle;
            end
            if (r_chk_idx == '0) begin
                r_drop_handle <= rd_entry.handle;
            end
        end
        if (i_cmd.scan) begin
            r_chk_idx <= r_scan_idx;
        end
    end

    // Valid bits; a full-table enqueue leaves them all set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (i_cmd.commit) begin
            if (is_enqueue) begin
                r_slot_valid[enq_idx] <= 1'b1;
            end else if (r_req.operation == tptq_pkg::OP_TAKE && r_have_best) begin
                r_slot_valid[r_best_idx] <= 1'b0;
            end else if (r_req.operation == tptq_pkg::OP_REMOVE && r_sel_found) begin
                r_slot_valid[r_req.slot[IDX_W-1:0]] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_sts.scan_last = (r_scan_idx == LAST_IDX);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    a_commit_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit did not present a result");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.ready_count <= COUNT_W'(QUEUE_DEPTH)))
        else $error("ready count exceeds the number of slots");

    a_drop_lands_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.dropped) |-> (r_out.out_slot == SLOT_W'(QUEUE_DEPTH - 1)))
        else $error("eviction did not place the new entry in the last slot");

endmodule

// ----- rtl/core/timed_priority_tx_queue_top.sv -----
// ----------------------------------------------------------------------------
// timed_priority_tx_queue_top
// Slot table of queued transmit packets with release times and priorities.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_ready    tptq_pkg::t_in_item
//   out      output     o_out_valid / i_out_ready  tptq_pkg::t_out_item
//
// Every operation scans all QUEUE_DEPTH slots through the slot RAM read port,
// one slot per cycle, then checks the last slot read and commits its result to
// the out channel; a new item is accepted only after the previous one commits.
// Reset is synchronous and active low; it empties the table at once.
// A new transaction is accepted while the previous result still waits; the
// commit step waits only if that result has not been taken by then.
// ----------------------------------------------------------------------------
module timed_priority_tx_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tptq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tptq_pkg::t_out_item o_out_data
);

    tptq_pkg::t_dp_cmd dp_cmd;
    tptq_pkg::t_dp_sts dp_sts;

    tptq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    tptq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- bench/timed_priority_tx_queue_checker.sv -----
// ----------------------------------------------------------------------------
// timed_priority_tx_queue_checker
// Watches both channels of the transmit queue. It keeps its own copy of the
// slot table, works out the result of every accepted request, and compares
// each returned result field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module timed_priority_tx_queue_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  tptq_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  tptq_pkg::t_out_item i_out_data,
    output int                  o_mismatch_count,
    output int                  o_pending_count
);

    localparam int REPORT_LIMIT = 10;
    localparam int SLOT_W       = tptq_pkg::SLOT_W;
    localparam int COUNT_W      = tptq_pkg::COUNT_W;
    localparam int PRIO_W       = tptq_pkg::PRIO_W;

    logic                slot_used [QUEUE_DEPTH];
    tptq_pkg::t_entry    slot_store [QUEUE_DEPTH];
    tptq_pkg::t_out_item awaited_results [$];

    // Applies one request to the table copy and returns the result it gives.
    function automatic tptq_pkg::t_out_item apply_queue_op(input tptq_pkg::t_in_item req);
        tptq_pkg::t_out_item res;
        tptq_pkg::t_entry    fresh;
        logic                placed;
        int                  win_slot;
        logic [PRIO_W-1:0]   best_prio;
        res = '0;
        fresh.handle   = req.handle;
        fresh.prio     = req.priority_req;
        fresh.rel_time = req.release_time;
        // The ready count is taken before the request changes anything.
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (slot_used[i] && slot_store[i].rel_time <= req.now) begin
                res.ready_count = res.ready_count + COUNT_W'(1);
            end
        end
        case (req.operation) inside
            tptq_pkg::OP_ENQUEUE: begin
                placed = 1'b0;
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (!placed && !slot_used[i]) begin
                        slot_store[i] = fresh;
                        slot_used[i]  = 1'b1;
                        res.out_slot  = SLOT_W'(i);
                        placed        = 1'b1;
                    end
                end
                if (!placed) begin
                    // A full table loses whatever sits in slot 0.
                    res.dropped        = 1'b1;
                    res.dropped_handle = slot_store[0].handle;
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        slot_store[i] = slot_store[i+1];
                        slot_used[i]  = slot_used[i+1];
                    end
                    slot_store[QUEUE_DEPTH-1] = fresh;
                    slot_used[QUEUE_DEPTH-1]  = 1'b1;
                    res.out_slot              = SLOT_W'(QUEUE_DEPTH - 1);
                end
            end
            tptq_pkg::OP_TAKE: begin
                best_prio = tptq_pkg::PRIO_NEVER;
                win_slot  = -1;
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (slot_used[i] && slot_store[i].rel_time <= req.now &&
                        slot_store[i].prio < best_prio) begin
                        best_prio = slot_store[i].prio;
                        win_slot  = i;
                    end
                end
                if (win_slot >= 0) begin
                    res.found           = 1'b1;
                    res.out_handle      = slot_store[win_slot].handle;
                    res.out_slot        = SLOT_W'(win_slot);
                    slot_used[win_slot] = 1'b0;
                end
            end
            tptq_pkg::OP_PEEK, tptq_pkg::OP_REMOVE: begin
                if (req.slot < QUEUE_DEPTH && slot_used[req.slot]) begin
                    res.found      = 1'b1;
                    res.out_handle = slot_store[req.slot].handle;
                    res.out_slot   = req.slot;
                    if (req.operation == tptq_pkg::OP_REMOVE) begin
                        slot_used[req.slot] = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        tptq_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                slot_used[i]  = 1'b0;
                slot_store[i] = '0;
            end
            awaited_results.delete();
        end else begin
            // A result leaving at this edge always belongs to an earlier request.
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    if (o_mismatch_count < REPORT_LIMIT) begin
                        $display("unexpected result %h with nothing outstanding",
                                 i_out_data);
                    end
                    o_mismatch_count = o_mismatch_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.found !== i_out_data.found ||
                        want.out_handle !== i_out_data.out_handle ||
                        want.out_slot !== i_out_data.out_slot ||
                        want.dropped !== i_out_data.dropped ||
                        want.dropped_handle !== i_out_data.dropped_handle ||
                        want.ready_count !== i_out_data.ready_count) begin
                        if (o_mismatch_count < REPORT_LIMIT) begin
                            $display({"result mismatch: expected found=%b handle=%0d ",
                                      "slot=%0d dropped=%b dropped_handle=%0d ready=%0d, ",
                                      "got found=%b handle=%0d slot=%0d dropped=%b ",
                                      "dropped_handle=%0d ready=%0d"},
                                     want.found, want.out_handle, want.out_slot,
                                     want.dropped, want.dropped_handle, want.ready_count,
                                     i_out_data.found, i_out_data.out_handle,
                                     i_out_data.out_slot, i_out_data.dropped,
                                     i_out_data.dropped_handle, i_out_data.ready_count);
                        end
                        o_mismatch_count = o_mismatch_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(apply_queue_op(i_in_data));
            end
        end
        o_pending_count = awaited_results.size();
    end

endmodule

// ----- bench/timed_priority_tx_queue_top_test.sv -----
// ----------------------------------------------------------------------------
// timed_priority_tx_queue_top_test
// Drives the transmit queue with a short directed sequence and then with
// bursts of random requests that fill, drain and churn the slot table, under
// changing amounts of idling on both channels. The checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module timed_priority_tx_queue_top_test;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    localparam int OP_W     = tptq_pkg::OP_W;
    localparam int HANDLE_W = tptq_pkg::HANDLE_W;
    localparam int PRIO_W   = tptq_pkg::PRIO_W;
    localparam int TIME_W   = tptq_pkg::TIME_W;
    localparam int SLOT_W   = tptq_pkg::SLOT_W;

    // Operation codes the block does not use.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED
    } t_burst_kind;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    tptq_pkg::t_in_item  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    tptq_pkg::t_out_item out_data;

    int mismatch_count;
    int pending_count;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    logic [TIME_W-1:0] time_base = '0;

    timed_priority_tx_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    timed_priority_tx_queue_checker #(
        .QUEUE_DEPTH(DEPTH)
    ) queue_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_data),
        .o_mismatch_count(mismatch_count),
        .o_pending_count (pending_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic tptq_pkg::t_in_item build_request(input logic [OP_W-1:0] op,
                                                         input int hnd, input int prio,
                                                         input logic [TIME_W-1:0] rel,
                                                         input logic [TIME_W-1:0] at,
                                                         input int slot);
        tptq_pkg::t_in_item req;
        req.operation    = op;
        req.handle       = HANDLE_W'(hnd);
        req.priority_req = PRIO_W'(prio);
        req.release_time = rel;
        req.now          = at;
        req.slot         = SLOT_W'(slot);
        return req;
    endfunction

    // Mostly close to a slowly moving base so that readiness is often borderline.
    function automatic logic [TIME_W-1:0] pick_time();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return '0;
        end else if (roll < 16) begin
            return TIME_MAX;
        end else if (roll < 24) begin
            return $urandom;
        end
        return time_base + TIME_W'($urandom_range(64)) - 32'd32;
    endfunction

    function automatic tptq_pkg::t_in_item random_request(input t_burst_kind kind);
        tptq_pkg::t_in_item req;
        int                 roll;
        logic [OP_W-1:0]    op;
        roll = $urandom_range(99);
        case (kind)
            BURST_FILL: begin
                if (roll < 75) op = tptq_pkg::OP_ENQUEUE;
                else if (roll < 85) op = tptq_pkg::OP_TAKE;
                else if (roll < 90) op = tptq_pkg::OP_PEEK;
                else if (roll < 95) op = tptq_pkg::OP_COUNT;
                else op = tptq_pkg::OP_REMOVE;
            end
            BURST_DRAIN: begin
                if (roll < 10) op = tptq_pkg::OP_ENQUEUE;
                else if (roll < 55) op = tptq_pkg::OP_TAKE;
                else if (roll < 70) op = tptq_pkg::OP_REMOVE;
                else if (roll < 85) op = tptq_pkg::OP_PEEK;
                else if (roll < 93) op = tptq_pkg::OP_COUNT;
                else op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            end
            default: begin
                if (roll < 35) op = tptq_pkg::OP_ENQUEUE;
                else if (roll < 60) op = tptq_pkg::OP_TAKE;
                else if (roll < 72) op = tptq_pkg::OP_PEEK;
                else if (roll < 84) op = tptq_pkg::OP_REMOVE;
                else if (roll < 94) op = tptq_pkg::OP_COUNT;
                else op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            end
        endcase
        if ($urandom_range(99) < 2) begin
            time_base = $urandom;
        end else begin
            time_base = time_base + TIME_W'($urandom_range(4));
        end
        req.operation    = op;
        req.handle       = HANDLE_W'($urandom_range(31));
        roll             = $urandom_range(99);
        req.priority_req = (roll < 15) ? tptq_pkg::PRIO_NEVER :
                           (roll < 30) ? PRIO_W'($urandom_range(3)) :
                                         PRIO_W'($urandom_range(255));
        req.release_time = pick_time();
        req.now          = pick_time();
        req.slot         = ($urandom_range(99) < 80) ? SLOT_W'($urandom_range(DEPTH - 1)) :
                                                       SLOT_W'($urandom_range(63));
        return req;
    endfunction

    // Holds the request on the channel until the block takes it.
    task automatic send_request(input tptq_pkg::t_in_item req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial begin : stimulus
        tptq_pkg::t_in_item req;
        t_burst_kind        kind;
        int                 burst_len;
        int                 sent;

        send_idle_pct = 16;
        recv_idle_pct = 88;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Empty table: counts, takes, peeks or removes that find nothing, and unused op codes.
        send_request(build_request(tptq_pkg::OP_COUNT, 0, 0, '0, '0, 0));
        send_request(build_request(tptq_pkg::OP_TAKE, 31, 255, TIME_MAX, TIME_MAX, 63));
        send_request(build_request(tptq_pkg::OP_PEEK, 0, 0, '0, '0, 0));
        send_request(build_request(tptq_pkg::OP_REMOVE, 0, 0, '0, '0, 63));
        send_request(build_request(OP_SPARE_LO, 31, 255, TIME_MAX, TIME_MAX, 63));
        send_request(build_request(OP_SPARE_HI, 0, 0, '0, TIME_MAX, 0));
        // Slot 0 latest time at best priority, slot 1 never served, two ties.
        send_request(build_request(tptq_pkg::OP_ENQUEUE, 31, 0, TIME_MAX, '0, 0));
        send_request(build_request(tptq_pkg::OP_ENQUEUE, 0, 255, '0, '0, 0));
        send_request(build_request(tptq_pkg::OP_ENQUEUE, 5, 7, 32'd100, '0, 0));
        send_request(build_request(tptq_pkg::OP_ENQUEUE, 6, 7, 32'd100, '0, 0));
        send_request(build_request(tptq_pkg::OP_TAKE, 0, 0, '0, 32'd99, 0));
        send_request(build_request(tptq_pkg::OP_TAKE, 0, 0, '0, 32'd100, 0));
        send_request(build_request(tptq_pkg::OP_COUNT, 0, 0, '0, 32'd100, 0));
        send_request(build_request(tptq_pkg::OP_PEEK, 0, 0, '0, '0, 1));
        send_request(build_request(tptq_pkg::OP_REMOVE, 0, 0, '0, '0, 1));
        send_request(build_request(tptq_pkg::OP_REMOVE, 0, 0, '0, '0, 1));
        send_request(build_request(tptq_pkg::OP_PEEK, 0, 0, '0, '0, DEPTH));
        send_request(build_request(tptq_pkg::OP_TAKE, 0, 0, '0, TIME_MAX, 0));
        send_request(build_request(tptq_pkg::OP_COUNT, 0, 0, '0, TIME_MAX, 0));
        send_request(build_request(tptq_pkg::OP_TAKE, 0, 0, '0, TIME_MAX, 0));

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind      = t_burst_kind'($urandom_range(BURST_MIXED, BURST_FILL));
            // Fill bursts can run long enough to wrap a full table.
            burst_len = (kind == BURST_FILL) ? $urandom_range(DEPTH + 8, 8) :
                                               $urandom_range(24, 4);
            for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
                if (sent < RANDOM_ITEMS / 3) begin
                    send_idle_pct = 16;
                    recv_idle_pct = 88;
                end else if (sent < 2 * RANDOM_ITEMS / 3) begin
                    send_idle_pct = 88;
                    recv_idle_pct = 16;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                req = random_request(kind);
                send_request(req);
                if (req.operation <= tptq_pkg::OP_COUNT) begin
                    sent++;
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
